/* rtl/core/b78enc_pkg.sv */
// Shared types and constants for the signed integer base-78 text encoder.
// No dependencies.
package b78enc_pkg;

	localparam int unsigned DigitSlots = 11;

	localparam logic [7:0] CharZero  = 8'd48;
	localparam logic [7:0] CharMinus = 8'd45;
	localparam logic [7:0] LeadBias  = 8'd10;

	localparam logic [31:0] CompactSingleMax = 32'd78;
	localparam logic [31:0] CompactDoubleMax = 32'd99;

	localparam logic [7:0] BaseDec     = 8'd10;
	localparam logic [7:0] BaseCompact = 8'd78;

	typedef logic [3:0] slot_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_SIGN,
		ST_DIGIT
	} state_t;

	typedef struct packed {
		logic        start;
		logic        base78;
		logic [31:0] dividend;
	} div_ctl_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quotient;
		logic [6:0]  remainder;
	} div_rsp_t;

endpackage

/* rtl/core/b78enc_div.sv */
// Iterative divider by a constant base (10 or 78), eight quotient bits per cycle.
// Depends on b78enc_pkg.
module b78enc_div (
	input  logic                clk,
	input  logic                arst_n,
	input  b78enc_pkg::div_ctl_t ctl,
	output b78enc_pkg::div_rsp_t rsp
);
	import b78enc_pkg::*;

	logic [31:0] work_q;
	logic [6:0]  rem_q;
	logic [1:0]  cnt_q;
	logic        busy_q;
	logic        done_q;

	logic [7:0]  qbits;
	logic [6:0]  rem_nxt;

	always_comb begin
		logic [7:0] r;
		logic [7:0] base;
		base  = ctl.base78 ? BaseCompact : BaseDec;
		r     = {1'b0, rem_q};
		qbits = '0;
		for (int i = 0; i < 8; i++) begin
			r = {r[6:0], work_q[31 - i]};
			if (r >= base) begin
				r            = r - base;
				qbits[7 - i] = 1'b1;
			end
		end
		rem_nxt = r[6:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			work_q <= ctl.dividend;
			rem_q  <= '0;
		end else if (busy_q) begin
			work_q <= {work_q[23:0], qbits};
			rem_q  <= rem_nxt;
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = work_q;
	assign rsp.remainder = rem_q;

endmodule

/* rtl/core/signed_int_base78_text_encoder.sv */
// Top level of the signed integer text encoder: sequencer, digit store, output register.
// Depends on b78enc_pkg and b78enc_div.
//
// channel  dir  handshake            payload
// in       in   in_valid/in_stall    value[31:0] signed
// out      out  out_valid/out_stall  char_code[7:0], last_char
// cfg      in   cfg_valid/cfg_ready  decimal_mode
//
// One request per item; in_stall is high from acceptance until the last character
// is loaded into the output register. Each digit is produced by the shared divider
// (eight quotient bits per cycle) before the characters are emitted, up to ten
// decimal digits and a sign. Compact-mode magnitudes 0..78 skip the divider.
// Output stalls hold the sequencer in emit.
// Reset clears control state and decimal_mode; the digit store needs no clearing.
module signed_int_base78_text_encoder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         char_code,
	output logic               last_char,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               decimal_mode
);
	import b78enc_pkg::*;

	state_t state_q, state_d;

	logic        dec_mode_q;
	logic        neg_q;
	logic        base78_q;
	slot_idx_t   n_q;
	logic        out_valid_q;
	logic [7:0]  char_q;
	logic        last_q;
	logic [7:0]  store_q [DigitSlots];

	div_ctl_t    div_ctl;
	div_rsp_t    div_rsp;

	logic [31:0] raw;
	logic [31:0] mag;
	logic        one_char;
	logic        in_acc;
	logic        out_ld;
	logic        more;
	logic        st_we;
	slot_idx_t   st_addr;
	logic [7:0]  st_data;
	slot_idx_t   rd_idx;

	b78enc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (div_ctl),
		.rsp    (div_rsp)
	);

	assign raw      = value;
	assign mag      = raw[31] ? (~raw + 32'd1) : raw;
	assign one_char = !dec_mode_q && (mag <= CompactSingleMax);
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_ld   = !out_valid_q || !out_stall;
	assign more     = (div_rsp.quotient != 32'd0) && (n_q < slot_idx_t'(DigitSlots - 1));
	assign rd_idx   = n_q - slot_idx_t'(1);
	assign cfg_ready = 1'b1;

	always_comb begin
		state_d          = state_q;
		div_ctl.start    = 1'b0;
		div_ctl.base78   = base78_q;
		div_ctl.dividend = div_rsp.quotient;
		st_we            = 1'b0;
		st_addr          = n_q;
		st_data          = {1'b0, div_rsp.remainder} + CharZero
			+ ((base78_q && !more) ? LeadBias : 8'd0);
		unique case (state_q)
			ST_IDLE: begin
				div_ctl.base78   = !dec_mode_q && (mag > CompactDoubleMax);
				div_ctl.dividend = mag;
				if (in_acc) begin
					if (one_char) begin
						st_we   = 1'b1;
						st_addr = '0;
						st_data = mag[7:0] + CharZero;
						state_d = raw[31] ? ST_SIGN : ST_DIGIT;
					end else begin
						div_ctl.start = 1'b1;
						state_d       = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					st_we = 1'b1;
					if (more) begin
						div_ctl.start = 1'b1;
					end else begin
						state_d = neg_q ? ST_SIGN : ST_DIGIT;
					end
				end
			end
			ST_SIGN: begin
				if (out_ld) begin
					state_d = ST_DIGIT;
				end
			end
			ST_DIGIT: begin
				if (out_ld && n_q == slot_idx_t'(1)) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_mode_q  <= 1'b0;
			neg_q       <= 1'b0;
			base78_q    <= 1'b0;
			n_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				dec_mode_q <= decimal_mode;
			end
			if (in_acc) begin
				neg_q    <= raw[31];
				base78_q <= div_ctl.base78;
				n_q      <= one_char ? slot_idx_t'(1) : slot_idx_t'(0);
			end else if (state_q == ST_DIV && div_rsp.done) begin
				n_q <= n_q + slot_idx_t'(1);
			end else if (state_q == ST_DIGIT && out_ld) begin
				n_q <= rd_idx;
			end
			if (out_ld) begin
				out_valid_q <= (state_q == ST_SIGN) || (state_q == ST_DIGIT);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_we) begin
			store_q[st_addr] <= st_data;
		end
		if (out_ld) begin
			if (state_q == ST_SIGN) begin
				char_q <= CharMinus;
				last_q <= 1'b0;
			end else begin
				char_q <= store_q[rd_idx];
				last_q <= (n_q == slot_idx_t'(1));
			end
		end
	end

	assign out_valid = out_valid_q;
	assign char_code = char_q;
	assign last_char = last_q;

endmodule

/* dv/tb_signed_int_base78_text_encoder.sv */
// Self-checking testbench for signed_int_base78_text_encoder: signed values in,
// every output character checked, in both compact and decimal modes.
// Depends on b78enc_pkg and the encoder RTL.
`timescale 1ns / 100ps

module tb_signed_int_base78_text_encoder;
	import b78enc_pkg::*;

	typedef struct packed {
		logic [7:0] code;
		logic       last;
	} text_char_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic signed [31:0] value = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [7:0]         char_code;
	logic               last_char;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic               decimal_mode = 1'b0;

	logic [31:0] pending_values[$];
	text_char_t  expected_chars[$];
	logic        mode_shadow = 1'b0;
	bit          calm = 1'b0;
	int          send_gap = 0;
	int          stall_left = 0;
	bit          drain_pause = 1'b0;
	int          mismatches = 0;

	signed_int_base78_text_encoder dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.value       (value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.char_code   (char_code),
		.last_char   (last_char),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.decimal_mode(decimal_mode)
	);

	always #5 clk = ~clk;

	// mostly short gaps, a few long ones, none during calm stretches
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic void encode_value(input logic [31:0] v, input logic dec);
		logic [31:0] mag;
		logic [31:0] q;
		logic [31:0] radix;
		logic [7:0]  digits[$];
		if (v[31])
			expected_chars.push_back('{CharMinus, 1'b0});
		mag = v[31] ? 32'd0 - v : v;
		if (!dec && mag <= CompactSingleMax) begin
			digits.push_back(mag[7:0] + CharZero);
		end else begin
			radix = (dec || mag <= CompactDoubleMax) ? 32'd10 : 32'd78;
			q = mag;
			do begin
				digits.push_back(8'(q % radix) + CharZero);
				q = q / radix;
			end while (q != 0 && digits.size() < DigitSlots);
			if (radix == 32'd78)
				digits[$] = digits[$] + LeadBias;
		end
		for (int i = digits.size() - 1; i >= 0; i--)
			expected_chars.push_back('{digits[i], i == 0});
	endfunction

	function automatic logic [31:0] rand_value();
		logic [31:0] mag;
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0, 1, 2: mag = $urandom_range(0, 78);
			3:       mag = $urandom_range(79, 99);
			4, 5:    mag = $urandom_range(100, $urandom_range(100, 500000));
			9: begin
				case ($urandom_range(0, 3))
					0:       return 32'h8000_0000;
					1:       return 32'h7FFF_FFFF;
					2:       return 32'h8000_0001;
					default: return 32'h7FFF_FFFF - $urandom_range(0, 255);
				endcase
			end
			default: return $urandom();
		endcase
		return $urandom_range(0, 1) ? 32'd0 - mag : mag;
	endfunction

	// sender: one request per value, predicted at acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			value <= '0;
			send_gap <= 0;
			drain_pause <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				encode_value(value, mode_shadow);
			if (!in_valid || !in_stall) begin
				if (send_gap != 0) begin
					in_valid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (drain_pause && expected_chars.size() != 0) begin
					in_valid <= 1'b0;
				end else if (pending_values.size() != 0) begin
					in_valid <= 1'b1;
					value <= pending_values.pop_front();
					send_gap <= pick_gap();
					drain_pause <= ($urandom_range(0, 99) < 3);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: random stall, compare against oldest expected character
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_chars.size() == 0) begin
					$error("unexpected char_code %0d last_char %0b", char_code, last_char);
					mismatches++;
				end else begin
					text_char_t want;
					want = expected_chars.pop_front();
					if (char_code !== want.code) begin
						$error("char_code expected %0d actual %0d", want.code, char_code);
						mismatches++;
					end
					if (last_char !== want.last) begin
						$error("last_char expected %0b actual %0b", want.last, last_char);
						mismatches++;
					end
				end
			end
			if (stall_left != 0) begin
				out_stall <= 1'b1;
				stall_left <= stall_left - 1;
			end else begin
				out_stall <= 1'b0;
				stall_left <= pick_gap();
			end
		end
	end

	task automatic wait_idle();
		while (pending_values.size() != 0 || in_valid || expected_chars.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_mode(input logic m);
		@(posedge clk);
		cfg_valid <= 1'b1;
		decimal_mode <= m;
		do
			@(posedge clk);
		while (!cfg_ready);
		mode_shadow = m;
		cfg_valid <= 1'b0;
		decimal_mode <= $urandom_range(0, 1);
	endtask

	task automatic push_directed();
		logic [31:0] corner[$];
		corner = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10, 32'd77, 32'd78,
			-32'sd78, 32'd79, -32'sd79, 32'd99, -32'sd99, 32'd100, -32'sd100, 32'd6083,
			32'd6084, 32'd1000000000, -32'sd999999999, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h8000_0001, 32'h5555_5555, 32'hAAAA_AAAA};
		foreach (corner[i])
			pending_values.push_back(corner[i]);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// reset mode is compact
		calm = 1'b1;
		push_directed();
		wait_idle();
		write_mode(1'b1);
		push_directed();
		wait_idle();
		write_mode(1'b0);
		calm = 1'b0;
		push_directed();
		wait_idle();

		for (int phase = 0; phase < 6; phase++) begin
			write_mode(phase % 3 == 1);
			calm = (phase == 3);
			repeat (60)
				pending_values.push_back(rand_value());
			wait_idle();
		end

		repeat (30) @(posedge clk);
		if (mismatches == 0 && expected_chars.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
